// File: hdl/hbk_pkg.sv
`default_nettype none
package hbk_pkg;

    localparam int KeyCount = 6;

    typedef struct packed {
        logic load;
        logic step;
        logic pop;
    } hbk_cmd_t;

    typedef struct packed {
        logic is_pop;
        logic last_key;
    } hbk_stat_t;

    // us layout translation; returns 0 for codes that give nothing
    function automatic logic [6:0] hbk_translate(input logic [7:0] code, input logic [7:0] mods);
        logic [6:0] c;
        logic       sh;
        sh = (mods[1] | mods[5]);
        c  = 7'd0;
        if (code >= 8'd4 && code <= 8'd29)
            c = 7'(code) + (sh ? 7'd61 : 7'd93);
        else if (!code[7])
        begin
            case (code[6:0])
                7'd30: c = sh ? 7'h21 : 7'h31;
                7'd31: c = sh ? 7'h40 : 7'h32;
                7'd32: c = sh ? 7'h23 : 7'h33;
                7'd33: c = sh ? 7'h24 : 7'h34;
                7'd34: c = sh ? 7'h25 : 7'h35;
                7'd35: c = sh ? 7'h5e : 7'h36;
                7'd36: c = sh ? 7'h26 : 7'h37;
                7'd37: c = sh ? 7'h2a : 7'h38;
                7'd38: c = sh ? 7'h28 : 7'h39;
                7'd39: c = sh ? 7'h29 : 7'h30;
                7'd40: c = 7'd10;
                7'd41: c = 7'd27;
                7'd42: c = 7'd8;
                7'd43: c = 7'd9;
                7'd44: c = 7'h20;
                7'd45: c = sh ? 7'h5f : 7'h2d;
                7'd46: c = sh ? 7'h2b : 7'h3d;
                7'd47: c = sh ? 7'h7b : 7'h5b;
                7'd48: c = sh ? 7'h7d : 7'h5d;
                7'd49: c = sh ? 7'h7c : 7'h5c;
                7'd50: c = sh ? 7'h7e : 7'h23;
                7'd51: c = sh ? 7'h3a : 7'h3b;
                7'd52: c = sh ? 7'h22 : 7'h27;
                7'd53: c = sh ? 7'h7e : 7'h60;
                7'd54: c = sh ? 7'h3c : 7'h2c;
                7'd55: c = sh ? 7'h3e : 7'h2e;
                7'd56: c = sh ? 7'h3f : 7'h2f;
                7'd84: c = 7'h2f;
                7'd85: c = 7'h2a;
                7'd86: c = 7'h2d;
                7'd87: c = 7'h2b;
                7'd88: c = 7'd10;
                7'd89: c = 7'h31;
                7'd90: c = 7'h32;
                7'd91: c = 7'h33;
                7'd92: c = 7'h34;
                7'd93: c = 7'h35;
                7'd94: c = 7'h36;
                7'd95: c = 7'h37;
                7'd96: c = 7'h38;
                7'd97: c = 7'h39;
                7'd98: c = 7'h30;
                7'd99: c = 7'h2e;
                default: c = 7'd0;
            endcase
        end
        if ((mods[0] | mods[4]) && code >= 8'd4 && code <= 8'd29)
            c = 7'(code - 8'd3);
        return c;
    endfunction

endpackage
`default_nettype wire

// File: hdl/hbk_ctrl.sv
`default_nettype none
module hbk_ctrl
    import hbk_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic in_valid,
    output logic      in_ready,
    output logic      out_valid,
    input  wire logic out_ready,
    input  wire hbk_stat_t stat,
    output hbk_cmd_t  cmd
);

    typedef enum logic [1:0] {IDLE, POP, KEYS, DONE} state_t;
    state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = stat.is_pop ? POP : KEYS;
                end
            end
            POP:
            begin
                cmd.pop    = 1'b1;
                state_next = DONE;
            end
            KEYS:
            begin
                cmd.step = 1'b1;
                if (stat.last_key)
                    state_next = DONE;
            end
            DONE:
            begin
                if (out_ready)
                    state_next = IDLE;
            end
            default: state_next = IDLE;
        endcase
    end

    assign in_ready  = (state_reg == IDLE);
    assign out_valid = (state_reg == DONE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= IDLE;
        else
            state_reg <= state_next;
    end

endmodule
`default_nettype wire

// File: hdl/hbk_datapath.sv
`default_nettype none
module hbk_datapath
    import hbk_pkg::*;
#(
    parameter int FIFO_DEPTH = 256
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire hbk_cmd_t   cmd,
    output hbk_stat_t       stat,
    input  wire logic       opcode,
    input  wire logic [7:0] modifier_bits,
    input  wire logic [7:0] key_0,
    input  wire logic [7:0] key_1,
    input  wire logic [7:0] key_2,
    input  wire logic [7:0] key_3,
    input  wire logic [7:0] key_4,
    input  wire logic [7:0] key_5,
    output logic [6:0]      char_out,
    output logic            char_valid,
    output logic [2:0]      chars_pushed,
    output logic [2:0]      chars_dropped,
    output logic            fifo_not_empty,
    output logic [7:0]      current_modifiers
);

    localparam int PtrW = $clog2(FIFO_DEPTH);

    logic [7:0]      prev_reg [KeyCount];
    logic [7:0]      keys_reg [KeyCount];
    logic [7:0]      mods_reg;
    logic [2:0]      idx_reg;
    logic [PtrW-1:0] wp_reg, rp_reg, wp_inc, rp_inc;
    logic [6:0]      mem [FIFO_DEPTH];
    logic [6:0]      chr;
    logic            held, full, do_push;

    assign wp_inc = (wp_reg == PtrW'(FIFO_DEPTH - 1)) ? '0 : wp_reg + 1'b1;
    assign rp_inc = (rp_reg == PtrW'(FIFO_DEPTH - 1)) ? '0 : rp_reg + 1'b1;
    assign full   = (wp_inc == rp_reg);

    // one key per cycle: compare against previous set, translate
    always_comb
    begin
        held = 1'b0;
        for (int i = 0; i < KeyCount; i++)
            if (prev_reg[i] == keys_reg[idx_reg]) held = 1'b1;
        chr     = hbk_translate(keys_reg[idx_reg], mods_reg);
        do_push = (keys_reg[idx_reg] != 8'd0) && !held && (chr != 7'd0);
    end

    assign stat.is_pop   = opcode;
    assign stat.last_key = (idx_reg == 3'(KeyCount - 1));
    assign fifo_not_empty    = (wp_reg != rp_reg);
    assign current_modifiers = mods_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.step && do_push && !full)
            mem[wp_reg] <= chr;
        if (cmd.pop)
            char_out <= (wp_reg != rp_reg) ? mem[rp_reg] : 7'd0;
        else if (cmd.load)
            char_out <= 7'd0;
        if (cmd.load)
        begin
            keys_reg[0] <= key_0;
            keys_reg[1] <= key_1;
            keys_reg[2] <= key_2;
            keys_reg[3] <= key_3;
            keys_reg[4] <= key_4;
            keys_reg[5] <= key_5;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < KeyCount; i++) prev_reg[i] <= '0;
            mods_reg      <= '0;
            wp_reg        <= '0;
            rp_reg        <= '0;
            idx_reg       <= '0;
            char_valid    <= 1'b0;
            chars_pushed  <= '0;
            chars_dropped <= '0;
        end
        else
        begin
            if (cmd.load)
            begin
                idx_reg       <= '0;
                char_valid    <= 1'b0;
                chars_pushed  <= '0;
                chars_dropped <= '0;
                if (!opcode) mods_reg <= modifier_bits;
            end
            if (cmd.pop && (wp_reg != rp_reg))
            begin
                char_valid <= 1'b1;
                rp_reg     <= rp_inc;
            end
            if (cmd.step)
            begin
                idx_reg <= idx_reg + 1'b1;
                if (do_push)
                begin
                    if (full)
                        chars_dropped <= chars_dropped + 1'b1;
                    else
                    begin
                        wp_reg       <= wp_inc;
                        chars_pushed <= chars_pushed + 1'b1;
                    end
                end
                if (stat.last_key)
                    for (int i = 0; i < KeyCount; i++) prev_reg[i] <= keys_reg[i];
            end
        end
    end

endmodule
`default_nettype wire

// File: hdl/hid_boot_keyboard_to_ascii_fifo.sv
// hid boot keyboard report decoder with character fifo
// input channel (in_valid/in_ready) carries one word: opcode 0 is a keyboard
// report (modifier_bits, key_0..key_5), opcode 1 pops one character.
// output channel (out_valid/out_ready) returns one result word per input.
// a report goes through accept, six key steps and result; a pop goes
// through accept, fifo read and result, and out_valid is high in the
// result step. the six key steps share one translate and one fifo write
// port, one key per cycle.
// the block takes one word at a time; in_ready stays low until the
// result word has been taken, so a stalled receiver holds off the input.
// reset clears the previous key set, modifiers and fifo pointers; the
// fifo holds FIFO_DEPTH-1 characters and needs no clearing pass.
// status outputs (modifiers, held flags, fifo_not_empty) refer to the
// state after the item.
`default_nettype none
module hid_boot_keyboard_to_ascii_fifo
    import hbk_pkg::*;
#(
    parameter int FIFO_DEPTH = 256
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic       opcode,
    input  wire logic [7:0] modifier_bits,
    input  wire logic [7:0] key_0,
    input  wire logic [7:0] key_1,
    input  wire logic [7:0] key_2,
    input  wire logic [7:0] key_3,
    input  wire logic [7:0] key_4,
    input  wire logic [7:0] key_5,
    output logic            out_valid,
    input  wire logic       out_ready,
    output logic [6:0]      char_out,
    output logic            char_valid,
    output logic [2:0]      chars_pushed,
    output logic [2:0]      chars_dropped,
    output logic            fifo_not_empty,
    output logic [7:0]      current_modifiers,
    output logic            shift_held,
    output logic            ctrl_held,
    output logic            alt_held
);

    hbk_cmd_t  cmd;
    hbk_stat_t stat;

    hbk_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    hbk_datapath #(.FIFO_DEPTH(FIFO_DEPTH)) u_dp (
        .clk               (clk),
        .rst_n             (rst_n),
        .cmd               (cmd),
        .stat              (stat),
        .opcode            (opcode),
        .modifier_bits     (modifier_bits),
        .key_0             (key_0),
        .key_1             (key_1),
        .key_2             (key_2),
        .key_3             (key_3),
        .key_4             (key_4),
        .key_5             (key_5),
        .char_out          (char_out),
        .char_valid        (char_valid),
        .chars_pushed      (chars_pushed),
        .chars_dropped     (chars_dropped),
        .fifo_not_empty    (fifo_not_empty),
        .current_modifiers (current_modifiers)
    );

    assign shift_held = current_modifiers[1] | current_modifiers[5];
    assign ctrl_held  = current_modifiers[0] | current_modifiers[4];
    assign alt_held   = current_modifiers[2] | current_modifiers[6];

    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid)) else $error("input and output open together");
    a_valid_char: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && char_valid |-> char_out != 7'd0) else $error("valid zero char");
    a_report_sum: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (4'(chars_pushed) + 4'(chars_dropped)) <= 4'd6)
        else $error("too many chars in one report");

endmodule
`default_nettype wire

// File: bench/tb_top.sv
`timescale 1ns / 1ps
`default_nettype none
module tb_top;
    import hbk_pkg::*;

    localparam int Depth     = 256;
    localparam int IdleLimit = 2000;
    localparam int NumRandom = 650;

    localparam bit OpReport = 1'b0;
    localparam bit OpPop    = 1'b1;

    typedef struct {
        bit [6:0] char_out;
        bit       char_valid;
        bit [2:0] chars_pushed;
        bit [2:0] chars_dropped;
        bit       fifo_not_empty;
        bit [7:0] current_modifiers;
        bit       shift_held;
        bit       ctrl_held;
        bit       alt_held;
    } key_result_t;

    class keyboard_scoreboard;
        bit [7:0]    held_keys[KeyCount];
        bit [7:0]    mods_q;
        bit [6:0]    char_ring[Depth];
        int unsigned wr_ptr;
        int unsigned rd_ptr;
        key_result_t expected_results[$];
        int          errors;

        function new();
            foreach (held_keys[i]) held_keys[i] = 8'd0;
            mods_q = 8'd0;
            wr_ptr = 0;
            rd_ptr = 0;
            errors = 0;
        endfunction

        function bit [6:0] key_to_char(bit [7:0] code, bit [7:0] mods);
            string digits;
            string plain_punct;
            string shift_punct;
            string shift_digits;
            string keypad;
            bit       sh;
            bit [7:0] c;
            digits       = "1234567890";
            shift_digits = "!@#$%^&*()";
            plain_punct  = "-=[]\\#;'`,./";
            shift_punct  = "_+{}|~:\"~<>?";
            keypad       = "1234567890.";
            sh = mods[1] | mods[5];
            c  = 8'd0;
            if (code >= 4 && code <= 29)
            begin
                // ctrl turns letters into control codes 1..26
                if (mods[0] | mods[4])
                    c = code - 8'd3;
                else
                    c = (sh ? 8'd65 : 8'd97) + code - 8'd4;
            end
            else if (code >= 30 && code <= 39)
                c = sh ? shift_digits[code - 30] : digits[code - 30];
            else if (code >= 45 && code <= 56)
                c = sh ? shift_punct[code - 45] : plain_punct[code - 45];
            else if (code >= 89 && code <= 99)
                c = keypad[code - 89];
            else
            begin
                case (code)
                    8'd40, 8'd88: c = 8'd10;
                    8'd41: c = 8'd27;
                    8'd42: c = 8'd8;
                    8'd43: c = 8'd9;
                    8'd44: c = 8'd32;
                    8'd84: c = 8'd47;
                    8'd85: c = 8'd42;
                    8'd86: c = 8'd45;
                    8'd87: c = 8'd43;
                    default: c = 8'd0;
                endcase
            end
            return c[6:0];
        endfunction

        function void note_word(bit op, bit [7:0] m, bit [5:0][7:0] keys);
            key_result_t r;
            bit       held;
            bit [6:0] c;
            int unsigned nxt;
            r = '{default: 0};
            if (op == OpPop)
            begin
                if (wr_ptr != rd_ptr)
                begin
                    r.char_out   = char_ring[rd_ptr];
                    r.char_valid = 1'b1;
                    rd_ptr = (rd_ptr + 1) % Depth;
                end
            end
            else
            begin
                mods_q = m;
                for (int i = 0; i < KeyCount; i++)
                begin
                    held = 1'b0;
                    foreach (held_keys[j])
                        if (held_keys[j] == keys[i]) held = 1'b1;
                    if (keys[i] == 8'd0 || held) continue;
                    c = key_to_char(keys[i], m);
                    if (c == 7'd0) continue;
                    nxt = (wr_ptr + 1) % Depth;
                    if (nxt != rd_ptr)
                    begin
                        char_ring[wr_ptr] = c;
                        wr_ptr = nxt;
                        r.chars_pushed++;
                    end
                    else
                        r.chars_dropped++;
                end
                for (int i = 0; i < KeyCount; i++) held_keys[i] = keys[i];
            end
            r.fifo_not_empty    = (wr_ptr != rd_ptr);
            r.current_modifiers = mods_q;
            r.shift_held        = mods_q[1] | mods_q[5];
            r.ctrl_held         = mods_q[0] | mods_q[4];
            r.alt_held          = mods_q[2] | mods_q[6];
            expected_results.push_back(r);
        endfunction

        function void check_result(key_result_t got);
            key_result_t e;
            if (expected_results.size() == 0)
            begin
                $error("result word with nothing expected");
                errors++;
                return;
            end
            e = expected_results.pop_front();
            if (got.char_out !== e.char_out)
            begin
                $error("char_out exp %0h got %0h", e.char_out, got.char_out); errors++;
            end
            if (got.char_valid !== e.char_valid)
            begin
                $error("char_valid exp %0d got %0d", e.char_valid, got.char_valid); errors++;
            end
            if (got.chars_pushed !== e.chars_pushed)
            begin
                $error("chars_pushed exp %0d got %0d", e.chars_pushed, got.chars_pushed);
                errors++;
            end
            if (got.chars_dropped !== e.chars_dropped)
            begin
                $error("chars_dropped exp %0d got %0d", e.chars_dropped, got.chars_dropped);
                errors++;
            end
            if (got.fifo_not_empty !== e.fifo_not_empty)
            begin
                $error("fifo_not_empty exp %0d got %0d", e.fifo_not_empty, got.fifo_not_empty);
                errors++;
            end
            if (got.current_modifiers !== e.current_modifiers)
            begin
                $error("current_modifiers exp %0h got %0h", e.current_modifiers,
                       got.current_modifiers);
                errors++;
            end
            if (got.shift_held !== e.shift_held)
            begin
                $error("shift_held exp %0d got %0d", e.shift_held, got.shift_held); errors++;
            end
            if (got.ctrl_held !== e.ctrl_held)
            begin
                $error("ctrl_held exp %0d got %0d", e.ctrl_held, got.ctrl_held); errors++;
            end
            if (got.alt_held !== e.alt_held)
            begin
                $error("alt_held exp %0d got %0d", e.alt_held, got.alt_held); errors++;
            end
        endfunction
    endclass

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_ready;
    logic       opcode;
    logic [7:0] modifier_bits;
    logic [7:0] key_0, key_1, key_2, key_3, key_4, key_5;
    logic       out_valid;
    logic       out_ready;
    logic [6:0] char_out;
    logic       char_valid;
    logic [2:0] chars_pushed;
    logic [2:0] chars_dropped;
    logic       fifo_not_empty;
    logic [7:0] current_modifiers;
    logic       shift_held;
    logic       ctrl_held;
    logic       alt_held;

    keyboard_scoreboard sb;
    int               idle_cycles;
    bit [5:0][7:0]    prior_keys;

    hid_boot_keyboard_to_ascii_fifo dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .opcode(opcode), .modifier_bits(modifier_bits),
        .key_0(key_0), .key_1(key_1), .key_2(key_2),
        .key_3(key_3), .key_4(key_4), .key_5(key_5),
        .out_valid(out_valid), .out_ready(out_ready),
        .char_out(char_out), .char_valid(char_valid),
        .chars_pushed(chars_pushed), .chars_dropped(chars_dropped),
        .fifo_not_empty(fifo_not_empty), .current_modifiers(current_modifiers),
        .shift_held(shift_held), .ctrl_held(ctrl_held), .alt_held(alt_held)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    initial
    begin
        sb = new();
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        out_ready     = 1'b0;
        opcode        = 1'b0;
        modifier_bits = 8'd0;
        {key_0, key_1, key_2, key_3, key_4, key_5} = '0;
    end

    // monitor: check older result before noting a new word
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
                sb.check_result('{char_out, char_valid, chars_pushed, chars_dropped,
                                  fifo_not_empty, current_modifiers, shift_held,
                                  ctrl_held, alt_held});
            if (in_valid && in_ready)
                sb.note_word(opcode, modifier_bits,
                             {key_5, key_4, key_3, key_2, key_1, key_0});
            if ((in_valid && in_ready) || (out_valid && out_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
        end
        else
            idle_cycles <= 0;
    end

    always @(posedge clk)
    begin
        if (idle_cycles >= IdleLimit)
        begin
            $display("hid_boot_keyboard_to_ascii_fifo regression: fail");
            $finish;
        end
    end

    // receiver with random stalls
    initial
    begin
        int g;
        @(posedge rst_n);
        forever
        begin
            g = $urandom_range(0, 16);
            @(negedge clk);
            if (g > 0)
            begin
                out_ready <= 1'b0;
                repeat (g) @(negedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
            while (!out_valid) @(posedge clk);
        end
    end

    task automatic send_word(input bit op, input bit [7:0] m, input bit [5:0][7:0] keys);
        int g;
        g = $urandom_range(0, 16);
        @(negedge clk);
        if (g > 0)
        begin
            in_valid <= 1'b0;
            repeat (g) @(negedge clk);
        end
        in_valid      <= 1'b1;
        opcode        <= op;
        modifier_bits <= m;
        {key_5, key_4, key_3, key_2, key_1, key_0} <= keys;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        if (op == OpReport) prior_keys = keys;
    endtask

    task automatic pop_char();
        send_word(OpPop, 8'($urandom), 48'({$urandom, $urandom}));
    endtask

    function automatic bit [7:0] pick_key();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 8'($urandom_range(4, 56));
        if (r < 65) return 8'($urandom_range(84, 99));
        if (r < 75) return prior_keys[$urandom_range(0, 5)];
        if (r < 85) return 8'd0;
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic bit [7:0] pick_mods();
        bit [7:0] common[6];
        common = '{8'h00, 8'h02, 8'h20, 8'h01, 8'h10, 8'h22};
        if ($urandom_range(0, 1)) return 8'($urandom);
        return common[$urandom_range(0, 5)];
    endfunction

    initial
    begin
        bit [5:0][7:0] k;
        int            pop_pct;
        prior_keys = '0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // empty pop, then plain, shifted, ctrl, extreme codes
        pop_char();
        send_word(OpReport, 8'h00, {8'd56, 8'd39, 8'd30, 8'd29, 8'd4, 8'd44});
        send_word(OpReport, 8'h02, {8'd56, 8'd45, 8'd53, 8'd50, 8'd31, 8'd5});
        send_word(OpReport, 8'h20, {8'd57, 8'd47, 8'd52, 8'd29, 8'd4, 8'd0});
        send_word(OpReport, 8'h01, {8'd30, 8'd84, 8'd99, 8'd29, 8'd4, 8'd0});
        send_word(OpReport, 8'h10, {8'd0, 8'd0, 8'd0, 8'd40, 8'd6, 8'd5});
        // codes of 128 and up, table holes, all modifiers
        send_word(OpReport, 8'hff, {8'd255, 8'd128, 8'd127, 8'd100, 8'd3, 8'd1});
        send_word(OpReport, 8'h00, {8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0});
        // repeated code within a report, then a held code
        send_word(OpReport, 8'h44, {8'd7, 8'd7, 8'd7, 8'd41, 8'd42, 8'd43});
        send_word(OpReport, 8'h00, {8'd7, 8'd88, 8'd87, 8'd86, 8'd85, 8'd43});
        send_word(OpReport, 8'h22, {8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0});
        repeat (8) pop_char();
        repeat (20) pop_char();

        // random phases: push-heavy phases fill the fifo to the drop point
        for (int n = 0; n < NumRandom; n++)
        begin
            if (n % 40 == 0)
            begin
                case ($urandom_range(0, 3))
                    0: pop_pct = 3;
                    1: pop_pct = 30;
                    2: pop_pct = 55;
                    default: pop_pct = 92;
                endcase
            end
            if ($urandom_range(0, 99) < pop_pct)
                pop_char();
            else
            begin
                for (int i = 0; i < KeyCount; i++) k[i] = pick_key();
                send_word(OpReport, pick_mods(), k);
            end
        end

        @(negedge clk);
        in_valid <= 1'b0;
        while (sb.expected_results.size() != 0) @(posedge clk);
        repeat (20) @(posedge clk);
        if (sb.errors == 0 && sb.expected_results.size() == 0)
            $display("hid_boot_keyboard_to_ascii_fifo regression: pass");
        else
            $display("hid_boot_keyboard_to_ascii_fifo regression: fail");
        $finish;
    end
endmodule
`default_nettype wire

// File: sim.f
hdl/hbk_pkg.sv
hdl/hbk_ctrl.sv
hdl/hbk_datapath.sv
hdl/hid_boot_keyboard_to_ascii_fifo.sv
bench/tb_top.sv
